>>> design/ghr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ghr_pkg
// Shared types and constants of the generational handle registry.
// ----------------------------------------------------------------------------
package ghr_pkg;

    // Default sizing, handed to the top level parameters
    localparam int NUM_SLOTS_DEF = 64;
    localparam int NUM_VIEWS_DEF = 64;
    localparam int GEN_BITS_DEF  = 16;

    // Fixed field widths of the stream payload
    localparam int CMD_W   = 2;
    localparam int HSLOT_W = 6;
    localparam int HGEN_W  = 16;
    localparam int VIEW_W  = 6;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE   = 2'd0,
        CMD_ERASE    = 2'd1,
        CMD_SET_VIEW = 2'd2,
        CMD_LOOKUP   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_STALE     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD1,
        S_RD2,
        S_WR2
    } state_t;

endpackage : ghr_pkg
`default_nettype wire

>>> design/generational_handle_registry_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_registry_unit
// Handle allocator with generation counters, a LIFO free list and per-view
// attach counts, all held in single-port-write synchronous memories.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Fields (lowest bit first)
//  --------+-----+-----------------------------------------------------------
//  s_      | in  | tdata: cmd[1:0] handle_slot[7:2] handle_gen[23:8]
//          |     |        view_id[29:24], zero fill [31:30]
//  m_      | out | tdata: status[1:0] out_slot[7:2] out_gen[23:8]
//          |     |        out_view[29:24] view_count[36:30], zero fill [39:37]
//
//  Sequence: create and rejected commands load the result from S_RD1;
//  lookup, erase and set view go on to S_RD2 and load it there, and a move
//  to another view adds S_WR2. The registered memory read and the single
//  count write port set this sequence.
//  Reset: aresetn sweeps every count memory entry to zero with s_tready
//  low. Stalls: a command is taken while the previous result waits;
//  a finished command holds until the output register frees.
//
module generational_handle_registry_unit #(
    parameter int NUM_SLOTS = ghr_pkg::NUM_SLOTS_DEF,
    parameter int NUM_VIEWS = ghr_pkg::NUM_VIEWS_DEF,
    parameter int GEN_BITS  = ghr_pkg::GEN_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // cmd[1:0], handle_slot[7:2], handle_gen[23:8], view_id[29:24]
    input  wire logic [ghr_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // status[1:0], out_slot[7:2], out_gen[23:8], out_view[29:24],
    // view_count[36:30]
    output logic [ghr_pkg::M_TDATA_W-1:0]        m_tdata
);
    import ghr_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);       // slot memory index
    localparam int HW_W   = $clog2(NUM_SLOTS + 1);   // fill/stack counters
    localparam int VW_W   = $clog2(NUM_VIEWS);       // count memory index
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);   // attach count
    localparam int GEN_W  = GEN_BITS;

    // ------------------------------------------------------------------
    // Memories. Slot entries below high water have all been written at
    // their first create, so the fill count stands in for a reset.
    // ------------------------------------------------------------------
    logic             slot_valid_mem [NUM_SLOTS];
    logic [GEN_W-1:0] slot_gen_mem   [NUM_SLOTS];
    logic [VW_W-1:0]  slot_view_mem  [NUM_SLOTS];
    logic [SLOT_W-1:0] fs_slot_mem   [NUM_SLOTS];
    logic [GEN_W-1:0] fs_gen_mem     [NUM_SLOTS];
    logic [CNT_W-1:0] cnt_mem        [NUM_VIEWS];

    // Registered read data
    logic              slot_valid_q;
    logic [GEN_W-1:0]  slot_gen_q;
    logic [VW_W-1:0]   slot_view_q;
    logic [SLOT_W-1:0] fs_slot_q;
    logic [GEN_W-1:0]  fs_gen_q;
    logic [CNT_W-1:0]  cnt_q;

    // Control state
    state_t            state_reg, state_next;
    logic [HW_W-1:0]   free_count_reg, free_count_next;
    logic [HW_W-1:0]   high_water_reg, high_water_next;
    logic [VW_W-1:0]   clr_idx_reg, clr_idx_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // Captured command
    cmd_t              cmd_reg;
    logic [HSLOT_W-1:0] hs_reg;
    logic [HGEN_W-1:0] hg_reg;
    logic [VIEW_W-1:0] vw_reg;
    logic [CNT_W-1:0]  cnt_new_reg, cnt_new_next;

    // Result register
    status_t           r_status_reg, r_status_next;
    logic [HSLOT_W-1:0] r_slot_reg, r_slot_next;
    logic [HGEN_W-1:0] r_gen_reg, r_gen_next;
    logic [VIEW_W-1:0] r_view_reg, r_view_next;
    logic [COUNT_W-1:0] r_count_reg, r_count_next;

    // Memory control
    logic              slot_we;
    logic [SLOT_W-1:0] slot_wa;
    logic              slot_valid_wd;
    logic [GEN_W-1:0]  slot_gen_wd;
    logic [VW_W-1:0]   slot_view_wd;
    logic              fs_we;
    logic              cnt_we;
    logic [VW_W-1:0]   cnt_wa;
    logic [CNT_W-1:0]  cnt_wd;
    logic              cnt_re;
    logic [VW_W-1:0]   cnt_ra;
    logic              ld_out;

    // Decode helpers
    logic              accept;
    logic              out_free;
    logic              vw_ok;
    logic              hs_ok;
    logic              req_ok;
    logic              clr_done;
    logic              view_moves;
    logic [VW_W-1:0]   vw_idx;
    logic [SLOT_W-1:0] hs_idx;
    logic [GEN_W-1:0]  gen_adv;
    logic [CNT_W-1:0]  old_dec;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;

    assign vw_idx   = VW_W'(32'(vw_reg));
    assign hs_idx   = SLOT_W'(32'(hs_reg));
    assign vw_ok    = 32'(vw_reg) < NUM_VIEWS;
    assign hs_ok    = (hg_reg != '0) && (32'(hs_reg) < 32'(high_water_reg))
                      && slot_valid_q && (32'(slot_gen_q) == 32'(hg_reg));
    assign req_ok   = hs_ok && ((cmd_reg != CMD_SET_VIEW) || vw_ok);
    assign clr_done = (clr_idx_reg == VW_W'(NUM_VIEWS - 1));
    assign view_moves = (slot_view_q != vw_idx);

    // Advance the generation, skipping zero on wrap
    assign gen_adv  = ((slot_gen_q + GEN_W'(1)) == '0) ? GEN_W'(1)
                                                       : slot_gen_q + GEN_W'(1);
    // Saturating decrement of the old view's count
    assign old_dec  = (cnt_q == '0) ? cnt_q : cnt_q - CNT_W'(1);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_RD1;
                end
            end
            S_RD1: begin
                if (cmd_reg == CMD_CREATE || !req_ok) begin
                    if (out_free) begin
                        state_next = S_IDLE;
                    end
                end else begin
                    state_next = S_RD2;
                end
            end
            S_RD2: begin
                if (out_free) begin
                    if (cmd_reg == CMD_SET_VIEW && view_moves) begin
                        state_next = S_WR2;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_WR2: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and memory control
    // ------------------------------------------------------------------
    always_comb begin
        free_count_next = free_count_reg;
        high_water_next = high_water_reg;
        clr_idx_next    = clr_idx_reg;
        cnt_new_next    = cnt_new_reg;

        slot_we       = 1'b0;
        slot_wa       = hs_idx;
        slot_valid_wd = slot_valid_q;
        slot_gen_wd   = slot_gen_q;
        slot_view_wd  = slot_view_q;
        fs_we         = 1'b0;
        cnt_we        = 1'b0;
        cnt_wa        = vw_idx;
        cnt_wd        = cnt_q;
        cnt_re        = 1'b0;
        cnt_ra        = VW_W'(32'(s_tdata[29:24]));
        ld_out        = 1'b0;

        r_status_next = ST_STALE;
        r_slot_next   = '0;
        r_gen_next    = '0;
        r_view_next   = '0;
        r_count_next  = '0;

        case (state_reg)
            S_CLEAR: begin
                // sweep the count memory to zero
                cnt_we       = 1'b1;
                cnt_wa       = clr_idx_reg;
                cnt_wd       = '0;
                clr_idx_next = clr_idx_reg + VW_W'(1);
            end
            S_IDLE: begin
                // count of the target view is read with the transfer
                cnt_re = accept;
            end
            S_RD1: begin
                if (cmd_reg == CMD_CREATE) begin
                    ld_out = out_free;
                    if (!vw_ok) begin
                        r_status_next = ST_STALE;
                    end else if (free_count_reg != '0) begin
                        // pop the most recently freed slot
                        r_status_next   = ST_OK;
                        r_slot_next     = HSLOT_W'(32'(fs_slot_q));
                        r_gen_next      = HGEN_W'(32'(fs_gen_q));
                        slot_wa         = fs_slot_q;
                        slot_gen_wd     = fs_gen_q;
                        free_count_next = out_free ? free_count_reg - HW_W'(1)
                                                   : free_count_reg;
                    end else if (32'(high_water_reg) < NUM_SLOTS) begin
                        // take a never-used slot at generation one
                        r_status_next   = ST_OK;
                        r_slot_next     = HSLOT_W'(32'(high_water_reg));
                        r_gen_next      = HGEN_W'(1);
                        slot_wa         = SLOT_W'(32'(high_water_reg));
                        slot_gen_wd     = GEN_W'(1);
                        high_water_next = out_free ? high_water_reg + HW_W'(1)
                                                   : high_water_reg;
                    end else begin
                        r_status_next = ST_EXHAUSTED;
                    end
                    if (vw_ok && r_status_next == ST_OK) begin
                        r_view_next   = vw_reg;
                        r_count_next  = COUNT_W'(32'(cnt_q + CNT_W'(1)));
                        slot_we       = out_free;
                        slot_valid_wd = 1'b1;
                        slot_view_wd  = vw_idx;
                        cnt_we        = out_free;
                        cnt_wa        = vw_idx;
                        cnt_wd        = cnt_q + CNT_W'(1);
                    end
                end else if (!req_ok) begin
                    ld_out = out_free;
                end else begin
                    // hold the new view's count, fetch the bound view's count
                    cnt_new_next = cnt_q;
                    cnt_re       = 1'b1;
                    cnt_ra       = slot_view_q;
                end
            end
            S_RD2: begin
                ld_out        = out_free;
                r_status_next = ST_OK;
                r_slot_next   = hs_reg;
                r_gen_next    = hg_reg;
                r_view_next   = VIEW_W'(32'(slot_view_q));
                r_count_next  = COUNT_W'(32'(cnt_q));
                case (cmd_reg)
                    CMD_ERASE: begin
                        r_count_next    = COUNT_W'(32'(old_dec));
                        cnt_we          = out_free;
                        cnt_wa          = slot_view_q;
                        cnt_wd          = old_dec;
                        slot_we         = out_free;
                        slot_valid_wd   = 1'b0;
                        slot_gen_wd     = gen_adv;
                        fs_we           = out_free;
                        free_count_next = out_free ? free_count_reg + HW_W'(1)
                                                   : free_count_reg;
                    end
                    CMD_SET_VIEW: begin
                        r_view_next = vw_reg;
                        if (view_moves) begin
                            r_count_next = COUNT_W'(32'(cnt_new_reg + CNT_W'(1)));
                            cnt_we       = out_free;
                            cnt_wa       = slot_view_q;
                            cnt_wd       = old_dec;
                            slot_we      = out_free;
                            slot_view_wd = vw_idx;
                        end else begin
                            r_count_next = COUNT_W'(32'(cnt_new_reg));
                        end
                    end
                    default: begin
                        // lookup reports the bound view as read
                    end
                endcase
            end
            S_WR2: begin
                // second half of a view move: bump the new view
                cnt_we = 1'b1;
                cnt_wa = vw_idx;
                cnt_wd = cnt_new_reg + CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid_next = ld_out | (m_tvalid_reg & ~m_tready);

    // ------------------------------------------------------------------
    // Memories: write and registered read
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_valid_mem[slot_wa] <= slot_valid_wd;
            slot_gen_mem[slot_wa]   <= slot_gen_wd;
            slot_view_mem[slot_wa]  <= slot_view_wd;
        end
        if (accept) begin
            slot_valid_q <= slot_valid_mem[SLOT_W'(32'(s_tdata[7:2]))];
            slot_gen_q   <= slot_gen_mem[SLOT_W'(32'(s_tdata[7:2]))];
            slot_view_q  <= slot_view_mem[SLOT_W'(32'(s_tdata[7:2]))];
        end
    end

    always_ff @(posedge aclk) begin
        if (fs_we) begin
            fs_slot_mem[SLOT_W'(free_count_reg)] <= hs_idx;
            fs_gen_mem[SLOT_W'(free_count_reg)]  <= gen_adv;
        end
        if (accept) begin
            fs_slot_q <= fs_slot_mem[SLOT_W'(free_count_reg - HW_W'(1))];
            fs_gen_q  <= fs_gen_mem[SLOT_W'(free_count_reg - HW_W'(1))];
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cnt_re) begin
            cnt_q <= cnt_mem[cnt_ra];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            free_count_reg <= '0;
            high_water_reg <= '0;
            clr_idx_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            high_water_reg <= high_water_next;
            clr_idx_reg    <= clr_idx_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= cmd_t'(s_tdata[1:0]);
            hs_reg  <= s_tdata[7:2];
            hg_reg  <= s_tdata[23:8];
            vw_reg  <= s_tdata[29:24];
        end
        cnt_new_reg <= cnt_new_next;
        if (ld_out) begin
            r_status_reg <= r_status_next;
            r_slot_reg   <= r_slot_next;
            r_gen_reg    <= r_gen_next;
            r_view_reg   <= r_view_next;
            r_count_reg  <= r_count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, r_count_reg, r_view_reg, r_gen_reg, r_slot_reg,
                       r_status_reg};

endmodule : generational_handle_registry_unit
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the generational handle registry. A scoreboard class
// keeps its own copy of the slot, generation, free-stack and attach-count
// state, predicts the reply to every accepted command and compares each
// reply transfer field by field. Stimulus is a short directed run followed by
// random create/erase/set-view/lookup traffic that alternates between filling
// and draining the registry, under three sender/receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import ghr_pkg::*;

    localparam int NUM_SLOTS  = NUM_SLOTS_DEF;
    localparam int NUM_VIEWS  = NUM_VIEWS_DEF;
    localparam int RAND_ITEMS = 950;
    localparam int MAX_SHOWN  = 10;

    // Command word as it travels on s_tdata, lowest field last in the list
    typedef struct packed {
        logic [1:0]         fill;
        logic [VIEW_W-1:0]  view;
        logic [HGEN_W-1:0]  gen;
        logic [HSLOT_W-1:0] slot;
        cmd_t               cmd;
    } cmd_word_t;

    // Reply word as it travels on m_tdata
    typedef struct packed {
        logic [2:0]         fill;
        logic [COUNT_W-1:0] count;
        logic [VIEW_W-1:0]  view;
        logic [HGEN_W-1:0]  gen;
        logic [HSLOT_W-1:0] slot;
        status_t            status;
    } reply_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the registry state and holds the replies still owed
    // ------------------------------------------------------------------------
    class registry_scoreboard;
        bit                slot_live  [NUM_SLOTS];
        logic [HGEN_W-1:0] slot_gen   [NUM_SLOTS];
        int                slot_view  [NUM_SLOTS];
        int                free_stack [NUM_SLOTS];
        int                attach     [NUM_VIEWS];
        int                free_cnt;
        int                high_water;
        int                live_now;
        int                peak_live;
        reply_t            owed_replies[$];
        int                mismatches;
        int                n_ok;
        int                n_exhausted;
        int                n_stale;

        function new();
            int i;
            for (i = 0; i < NUM_SLOTS; i++) begin
                slot_live[i]  = 1'b0;
                slot_gen[i]   = HGEN_W'(1);
                slot_view[i]  = 0;
                free_stack[i] = 0;
            end
            for (i = 0; i < NUM_VIEWS; i++) attach[i] = 0;
            free_cnt    = 0;
            high_water  = 0;
            live_now    = 0;
            peak_live   = 0;
            mismatches  = 0;
            n_ok        = 0;
            n_exhausted = 0;
            n_stale     = 0;
        endfunction

        // Advance the mirrored state by one command and return its reply
        function reply_t apply_command(cmd_word_t w);
            reply_t r;
            int     s;
            int     old;
            r        = '0;
            r.status = ST_STALE;
            if (w.cmd == CMD_CREATE) begin
                if (int'(w.view) >= NUM_VIEWS) return r;
                // LIFO reuse first, then the next never-used slot
                if (free_cnt > 0) begin
                    free_cnt--;
                    s = free_stack[free_cnt];
                end else if (high_water < NUM_SLOTS) begin
                    s = high_water;
                    high_water++;
                end else begin
                    r.status = ST_EXHAUSTED;
                    return r;
                end
                slot_live[s] = 1'b1;
                slot_view[s] = int'(w.view);
                attach[w.view]++;
                live_now++;
                if (live_now > peak_live) peak_live = live_now;
                r.status = ST_OK;
                r.slot   = HSLOT_W'(s);
                r.gen    = slot_gen[s];
                r.view   = w.view;
                r.count  = COUNT_W'(attach[w.view]);
                return r;
            end
            // View range is checked ahead of the handle for set view
            if (w.cmd == CMD_SET_VIEW && int'(w.view) >= NUM_VIEWS) return r;
            if (w.gen == '0 || int'(w.slot) >= high_water || !slot_live[w.slot]
                    || slot_gen[w.slot] != w.gen)
                return r;
            s        = int'(w.slot);
            old      = slot_view[s];
            r.status = ST_OK;
            r.slot   = w.slot;
            r.gen    = w.gen;
            case (w.cmd)
                CMD_ERASE: begin
                    if (attach[old] > 0) attach[old]--;
                    slot_live[s] = 1'b0;
                    live_now--;
                    // Generation wraps past zero straight to one
                    slot_gen[s] = slot_gen[s] + 1'b1;
                    if (slot_gen[s] == '0) slot_gen[s] = HGEN_W'(1);
                    if (free_cnt < NUM_SLOTS) begin
                        free_stack[free_cnt] = s;
                        free_cnt++;
                    end
                    r.view  = VIEW_W'(old);
                    r.count = COUNT_W'(attach[old]);
                end
                CMD_SET_VIEW: begin
                    if (old != int'(w.view)) begin
                        if (attach[old] > 0) attach[old]--;
                        slot_view[s] = int'(w.view);
                        attach[w.view]++;
                    end
                    r.view  = w.view;
                    r.count = COUNT_W'(attach[w.view]);
                end
                default: begin
                    r.view  = VIEW_W'(old);
                    r.count = COUNT_W'(attach[old]);
                end
            endcase
            return r;
        endfunction

        function void note_command(cmd_word_t w);
            owed_replies.insert(owed_replies.size(), apply_command(w));
        endfunction

        function void flag(string what, reply_t e, reply_t g);
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display({"tb_top: %s at %0t: expected st=%0d slot=%0d gen=%0d view=%0d",
                          " cnt=%0d fill=%0d, got st=%0d slot=%0d gen=%0d view=%0d",
                          " cnt=%0d fill=%0d"},
                         what, $time, e.status, e.slot, e.gen, e.view, e.count, e.fill,
                         g.status, g.slot, g.gen, g.view, g.count, g.fill);
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            case (got.status)
                ST_OK:        n_ok++;
                ST_EXHAUSTED: n_exhausted++;
                default:      n_stale++;
            endcase
            if (owed_replies.size() == 0) begin
                flag("reply with nothing owed", '0, got);
                return;
            end
            want = owed_replies.pop_front();
            if (got !== want) flag("reply mismatch", want, got);
        endfunction

        // Random live slot, or -1 when the registry is empty
        function int pick_live();
            int k;
            int i;
            if (live_now == 0) return -1;
            k = int'($urandom_range(live_now - 1));
            for (i = 0; i < NUM_SLOTS; i++) begin
                if (slot_live[i]) begin
                    if (k == 0) return i;
                    k--;
                end
            end
            return -1;
        endfunction

        // Random slot that was used and has since been erased, or -1
        function int pick_freed();
            int n;
            int k;
            int i;
            n = high_water - live_now;
            if (n <= 0) return -1;
            k = int'($urandom_range(n - 1));
            for (i = 0; i < high_water; i++) begin
                if (!slot_live[i]) begin
                    if (k == 0) return i;
                    k--;
                end
            end
            return -1;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block under test
    // ------------------------------------------------------------------------
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int tx_idle_pct = 19;
    int rx_idle_pct = 55;
    int hot_view    = 0;

    registry_scoreboard sb = new();

    always #10 aclk = ~aclk;

    generational_handle_registry_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Receiver: stall at random, one decision per clock
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Reply monitor: values read here are the ones present before the edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_reply(reply_t'(m_tdata));
    end

    // ------------------------------------------------------------------------
    // Sender: hold the command until the transfer, then note it for checking
    // ------------------------------------------------------------------------
    task automatic send_cmd(input cmd_t c, input int slot, input int gen, input int view);
        cmd_word_t w;
        // Random sender gaps; valid drops only if a gap actually happens
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        w      = '0;
        w.cmd  = c;
        w.slot = HSLOT_W'(slot);
        w.gen  = HGEN_W'(gen);
        w.view = VIEW_W'(view);
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_command(w);
    endtask

    // Mostly well-formed traffic on live handles, plus stale and junk handles
    task automatic send_random(input bit filling);
        int   r;
        int   s;
        int   f;
        int   g;
        int   v;
        cmd_t c;
        r = int'($urandom_range(99));
        if (filling)
            c = (r < 62) ? CMD_CREATE : (r < 72) ? CMD_ERASE :
                (r < 86) ? CMD_SET_VIEW : CMD_LOOKUP;
        else
            c = (r < 20) ? CMD_CREATE : (r < 62) ? CMD_ERASE :
                (r < 80) ? CMD_SET_VIEW : CMD_LOOKUP;
        v = ($urandom_range(99) < 40) ? hot_view : int'($urandom_range(NUM_VIEWS - 1));
        s = sb.pick_live();
        if (c == CMD_CREATE) begin
            // Handle fields are don't-care here: fill them with junk
            send_cmd(c, int'($urandom_range(63)), int'($urandom_range(65535)), v);
            return;
        end
        if (s >= 0 && $urandom_range(99) < 82) begin
            g = int'(sb.slot_gen[s]);
            // Sometimes move a handle to the view it already has
            if (c == CMD_SET_VIEW && $urandom_range(99) < 15) v = sb.slot_view[s];
            send_cmd(c, s, g, v);
            return;
        end
        case ($urandom_range(4))
            0: begin
                s = int'($urandom_range(63));
                g = int'($urandom_range(65535));
            end
            1: begin
                // Live slot, one generation bit flipped
                if (s < 0) s = int'($urandom_range(63));
                g = int'(sb.slot_gen[s] ^ (16'd1 << $urandom_range(15)));
            end
            2: begin
                // Erased slot presented with its previous generation
                f = sb.pick_freed();
                s = (f >= 0) ? f : int'($urandom_range(63));
                g = (f >= 0) ? int'(sb.slot_gen[f] - 1'b1) : int'($urandom_range(65535));
            end
            3: begin
                // Slot never handed out yet, with the reset generation
                s = (sb.high_water < NUM_SLOTS) ? sb.high_water : int'($urandom_range(63));
                g = 1;
            end
            default: begin
                if (s < 0) s = int'($urandom_range(63));
                g = 0;
            end
        endcase
        send_cmd(c, s, g, v);
    endtask

    task automatic run_directed();
        send_cmd(CMD_LOOKUP,   0,  1,      0);  // nothing handed out yet
        send_cmd(CMD_CREATE,   63, 16'hFFFF, 0);
        send_cmd(CMD_CREATE,   0,  0,      63);
        send_cmd(CMD_CREATE,   0,  0,      63);  // second attach to view 63
        send_cmd(CMD_LOOKUP,   1,  1,      0);
        send_cmd(CMD_SET_VIEW, 1,  1,      63);  // same view, counts hold
        send_cmd(CMD_SET_VIEW, 1,  1,      0);   // move one attach
        send_cmd(CMD_LOOKUP,   0,  0,      0);   // generation zero
        send_cmd(CMD_LOOKUP,   0,  16'hFFFF, 0); // wrong generation
        send_cmd(CMD_LOOKUP,   3,  1,      0);   // above the high-water mark
        send_cmd(CMD_ERASE,    2,  1,      0);
        send_cmd(CMD_ERASE,    2,  1,      0);   // double erase
        send_cmd(CMD_LOOKUP,   2,  2,      0);   // freed slot, current generation
        send_cmd(CMD_SET_VIEW, 2,  1,      5);
        send_cmd(CMD_CREATE,   0,  0,      42);  // reuses slot 2 at generation 2
        send_cmd(CMD_ERASE,    0,  1,      0);
        send_cmd(CMD_ERASE,    1,  1,      0);
        send_cmd(CMD_CREATE,   0,  0,      7);   // LIFO: slot 1 comes back first
        send_cmd(CMD_CREATE,   0,  0,      7);
        send_cmd(CMD_CREATE,   0,  0,      7);   // free stack empty: fresh slot
        send_cmd(CMD_LOOKUP,   63, 1,      0);
        send_cmd(CMD_SET_VIEW, 63, 16'hFFFF, 63);
        send_cmd(CMD_ERASE,    3,  1,      0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int  phase;
        int  left;
        int  run_len;
        bit  filling;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // The block sweeps its count memory first; the handshake covers it
        run_directed();
        filling = 1'b0;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin tx_idle_pct = 19; rx_idle_pct = 55; end
                1:       begin tx_idle_pct = 55; rx_idle_pct = 19; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            left = RAND_ITEMS / 3;
            while (left > 0) begin
                // Alternate fill and drain runs so exhaustion and reuse both occur
                filling  = !filling;
                run_len  = int'($urandom_range(60, 120));
                hot_view = int'($urandom_range(NUM_VIEWS - 1));
                while (run_len > 0 && left > 0) begin
                    send_random(filling);
                    run_len--;
                    left--;
                end
            end
        end
        s_tvalid <= 1'b0;
        while (sb.owed_replies.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        $display("tb_top: %0d replies checked: %0d ok, %0d exhausted, %0d unknown or stale",
                 sb.n_ok + sb.n_exhausted + sb.n_stale, sb.n_ok, sb.n_exhausted, sb.n_stale);
        $display("tb_top: peak live handles %0d of %0d, mismatches %0d",
                 sb.peak_live, NUM_SLOTS, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("tb_top: timeout with %0d replies outstanding", sb.owed_replies.size());
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> generational_handle_registry_unit.f
design/ghr_pkg.sv
design/generational_handle_registry_unit.sv
sim/tb_top.sv
